@@ hw/rtl/cwc_pkg.sv @@
// Shared types and constants for the camera window crop / overlay block.
// No dependencies; imported by every module of the block.
package cwc_pkg;

  localparam int COL_W  = 9;
  localparam int ROW_W  = 8;
  localparam int PIX_W  = 16;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_MODE  = 3'd4;

  localparam logic [COL_W-1:0] WIN_LEFT_RST   = 9'd130;
  localparam logic [ROW_W-1:0] WIN_TOP_RST    = 8'd20;
  localparam logic [COL_W-1:0] WIN_RIGHT_RST  = 9'd180;
  localparam logic [ROW_W-1:0] WIN_BOTTOM_RST = 8'd220;

  localparam logic [PIX_W-1:0] RED_PIXEL   = 16'hF800;
  localparam logic [PIX_W-1:0] WHITE_PIXEL = 16'hFFFF;

  typedef struct packed {
    logic [COL_W-1:0] win_left;
    logic [ROW_W-1:0] win_top;
    logic [COL_W-1:0] win_right;
    logic [ROW_W-1:0] win_bottom;
    logic             crop_mode;
  } cfg_t;

endpackage

@@ hw/rtl/cwc_unpack.sv @@
// Byte pairing and frame raster counters; holds one assembled pixel beat.
// Depends on cwc_pkg.
module cwc_unpack #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240,
  parameter int CW = 9,
  parameter int RW = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cwc_pkg::BYTE_W-1:0]  pixel_byte,
  input  logic                        frame_start,
  output logic                        s1_valid,
  input  logic                        s1_ready,
  output logic [cwc_pkg::PIX_W-1:0]   s1_camera,
  output logic [CW-1:0]               s1_col,
  output logic [RW-1:0]               s1_row,
  output logic                        s1_last
);
  import cwc_pkg::*;

  localparam logic [CW-1:0] LAST_COL = CW'(FRAME_WIDTH - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(FRAME_HEIGHT - 1);

  logic              low_byte_phase;
  logic [BYTE_W-1:0] saved_high_byte;
  logic [CW-1:0]     column_count;
  logic [RW-1:0]     row_count;
  logic              frame_finished;

  logic          accept;
  logic          fin_e, phase_e, emit, last;
  logic [CW-1:0] col_e;
  logic [RW-1:0] row_e;

  assign in_stall = s1_valid && !s1_ready;
  assign accept   = in_valid && !in_stall;

  // a frame-start mark restarts pairing and the raster before anything else
  assign fin_e   = frame_start ? 1'b0 : frame_finished;
  assign phase_e = frame_start ? 1'b0 : low_byte_phase;
  assign col_e   = frame_start ? '0 : column_count;
  assign row_e   = frame_start ? '0 : row_count;
  assign emit    = accept && !fin_e && phase_e;
  assign last    = (col_e == LAST_COL) && (row_e == LAST_ROW);

  always_ff @(posedge clk) begin
    if (rst) begin
      low_byte_phase  <= 1'b0;
      saved_high_byte <= '0;
      column_count    <= '0;
      row_count       <= '0;
      frame_finished  <= 1'b1;
    end else if (accept) begin
      frame_finished <= fin_e;
      low_byte_phase <= phase_e;
      column_count   <= col_e;
      row_count      <= row_e;
      if (!fin_e) begin
        if (!phase_e) begin
          saved_high_byte <= pixel_byte;
          low_byte_phase  <= 1'b1;
        end else begin
          low_byte_phase <= 1'b0;
          if (last) begin
            frame_finished <= 1'b1;
            column_count   <= '0;
            row_count      <= '0;
          end else if (col_e >= LAST_COL) begin
            column_count <= '0;
            row_count    <= row_e + 1'b1;
          end else begin
            column_count <= col_e + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (emit) begin
      s1_valid <= 1'b1;
    end else if (s1_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_camera <= {saved_high_byte, pixel_byte};
      s1_col    <= col_e;
      s1_row    <= row_e;
      s1_last   <= last;
    end
  end

`ifndef SYNTHESIS
  a_phase_idle: assert property (@(posedge clk) disable iff (rst)
    frame_finished |-> !low_byte_phase)
    else $error("pairing phase set while waiting for frame start");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    column_count <= LAST_COL)
    else $error("column counter beyond frame");
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_count <= LAST_ROW)
    else $error("row counter beyond frame");
  a_beat_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_camera) && $stable(s1_col)))
    else $error("stage beat lost while output stalled");
  a_beat_source: assert property (@(posedge clk) disable iff (rst)
    $rose(s1_valid) |-> $past(accept && low_byte_phase | accept && frame_start) == 1'b0
      || $past(accept))
    else $error("stage beat without an accepted byte");
`endif

endmodule

@@ hw/rtl/cwc_shade.sv @@
// Window shading and output register: overlay border or crop to white.
// Depends on cwc_pkg.
module cwc_shade #(
  parameter int CW = 9,
  parameter int RW = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cwc_pkg::cfg_t              cfg,
  input  logic                       s1_valid,
  output logic                       s1_ready,
  input  logic [cwc_pkg::PIX_W-1:0]  s1_camera,
  input  logic [CW-1:0]              s1_col,
  input  logic [RW-1:0]              s1_row,
  input  logic                       s1_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cwc_pkg::PIX_W-1:0]  pixel_value,
  output logic [cwc_pkg::COL_W-1:0]  column,
  output logic [cwc_pkg::ROW_W-1:0]  row,
  output logic                       frame_end
);
  import cwc_pkg::*;

  logic             in_cols, in_rows, on_row, on_col, load;
  logic [PIX_W-1:0] shaded;

  assign s1_ready = !out_valid || !out_stall;
  assign load     = s1_valid && s1_ready;

  assign in_cols = (s1_col > CW'(cfg.win_left)) && (s1_col < CW'(cfg.win_right));
  assign in_rows = (s1_row > RW'(cfg.win_top)) && (s1_row < RW'(cfg.win_bottom));
  assign on_row  = (s1_row == RW'(cfg.win_top)) || (s1_row == RW'(cfg.win_bottom));
  assign on_col  = (s1_col == CW'(cfg.win_left)) || (s1_col == CW'(cfg.win_right));

  always_comb begin
    if (cfg.crop_mode) begin
      shaded = (in_cols && in_rows) ? s1_camera : WHITE_PIXEL;
    end else if ((on_row && in_cols) || (on_col && in_rows)) begin
      shaded = RED_PIXEL;
    end else begin
      shaded = s1_camera;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_value <= shaded;
      column      <= s1_col[COL_W-1:0];
      row         <= s1_row[ROW_W-1:0];
      frame_end   <= s1_last;
    end
  end

endmodule

@@ hw/rtl/camera_window_crop_overlay.sv @@
// Top level: configuration registers, byte pairing stage, shading stage.
// Depends on cwc_pkg, cwc_unpack, cwc_shade.
//
//   channel | direction | handshake           | beat
//   in      | input     | in_valid / in_stall | pixel_byte, frame_start
//   out     | output    | out_valid/out_stall | pixel_value, column, row, frame_end
//   cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One byte accepted per cycle while in_stall is low; every second byte of a frame yields one pixel.
// out_valid rises once a pixel's low byte has been accepted into the pairing
// register and that pixel has then moved on into the output register.
// Synchronous reset restores the window defaults and waits for frame start.
// A stalled output holds; one more pixel waits in the pairing register,
// and in_stall rises only when both registers are full and out_stall is high.
module camera_window_crop_overlay #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cwc_pkg::BYTE_W-1:0]    pixel_byte,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cwc_pkg::PIX_W-1:0]     pixel_value,
  output logic [cwc_pkg::COL_W-1:0]     column,
  output logic [cwc_pkg::ROW_W-1:0]     row,
  output logic                          frame_end,
  input  logic                          cfg_we,
  input  logic [cwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cwc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cwc_pkg::*;

  // counters at least as wide as the coordinate fields they are compared with
  localparam int CW = ($clog2(FRAME_WIDTH) > COL_W) ? $clog2(FRAME_WIDTH) : COL_W;
  localparam int RW = ($clog2(FRAME_HEIGHT) > ROW_W) ? $clog2(FRAME_HEIGHT) : ROW_W;

  cfg_t cfg;

  logic             s1_valid, s1_ready, s1_last;
  logic [PIX_W-1:0] s1_camera;
  logic [CW-1:0]    s1_col;
  logic [RW-1:0]    s1_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_left   <= WIN_LEFT_RST;
      cfg.win_top    <= WIN_TOP_RST;
      cfg.win_right  <= WIN_RIGHT_RST;
      cfg.win_bottom <= WIN_BOTTOM_RST;
      cfg.crop_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIN_LEFT:   cfg.win_left   <= cfg_data[COL_W-1:0];
        REG_WIN_TOP:    cfg.win_top    <= cfg_data[ROW_W-1:0];
        REG_WIN_RIGHT:  cfg.win_right  <= cfg_data[COL_W-1:0];
        REG_WIN_BOTTOM: cfg.win_bottom <= cfg_data[ROW_W-1:0];
        REG_CROP_MODE:  cfg.crop_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cwc_unpack #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .CW          (CW),
    .RW          (RW)
  ) u_unpack (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .pixel_byte (pixel_byte),
    .frame_start(frame_start),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_camera  (s1_camera),
    .s1_col     (s1_col),
    .s1_row     (s1_row),
    .s1_last    (s1_last)
  );

  cwc_shade #(
    .CW(CW),
    .RW(RW)
  ) u_shade (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .s1_camera  (s1_camera),
    .s1_col     (s1_col),
    .s1_row     (s1_row),
    .s1_last    (s1_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_value(pixel_value),
    .column     (column),
    .row        (row),
    .frame_end  (frame_end)
  );

endmodule
